// ===== src/depth_sorted_insert_queue_core_defines.svh =====
// Assertion macros for the depth sorted insert queue.
// IMPLY checks a consequent in the same cycle, NEXT in the cycle after.
`ifndef DEPTH_SORTED_INSERT_QUEUE_CORE_DEFINES_SVH
`define DEPTH_SORTED_INSERT_QUEUE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define DSIQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DSIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DSIQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define DSIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/dsiq_pkg.sv =====
package dsiq_pkg;

    localparam int unsigned QUEUE_CAPACITY_DEF = 32;
    localparam int unsigned HANDLE_BITS_DEF    = 16;
    localparam int unsigned HANDLE_FIELD_W     = 16;
    localparam int unsigned KEY_W              = 32;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DRAIN  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_REJECTED = 2'd1,
        ST_DRAINED  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_DRAIN = 1'b1
    } t_state;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic rotate;
    } t_cell_ctl;

endpackage

// ===== src/dsiq_cell.sv =====
module dsiq_cell #(
    parameter int unsigned HW = 16
) (
    input  logic                i_clk,
    input  dsiq_pkg::t_cell_ctl i_ctl,
    input  logic                i_desc,
    input  logic                i_occupied,
    input  logic                i_wrap,
    input  dsiq_pkg::t_key      i_new_key,
    input  logic [HW-1:0]       i_new_handle,
    input  logic                i_left_ge,
    input  dsiq_pkg::t_key      i_left_key,
    input  logic [HW-1:0]       i_left_handle,
    input  dsiq_pkg::t_key      i_right_key,
    input  logic [HW-1:0]       i_right_handle,
    input  dsiq_pkg::t_key      i_head_key,
    input  logic [HW-1:0]       i_head_handle,
    output logic                o_ge,
    output dsiq_pkg::t_key      o_key,
    output logic [HW-1:0]       o_handle
);
    import dsiq_pkg::*;

    t_key          r_key;
    logic [HW-1:0] r_handle;
    t_key          n_key;
    logic [HW-1:0] n_handle;
    logic          w_stop;

    // stored entry must sit behind the new one (equal keys stay in front)
    assign w_stop = i_desc ? (r_key < i_new_key) : (r_key > i_new_key);
    // once a cell in front has stopped, every cell behind it shifts too;
    // the row need not be sorted after a direction change
    assign o_ge   = i_left_ge || !i_occupied || w_stop;

    always_comb begin
        n_key    = r_key;
        n_handle = r_handle;
        if (i_ctl.insert) begin
            if (o_ge && !i_left_ge) begin
                n_key    = i_new_key;
                n_handle = i_new_handle;
            end else if (o_ge) begin
                n_key    = i_left_key;
                n_handle = i_left_handle;
            end
        end else if (i_ctl.rotate) begin
            // last occupied cell closes the ring back to the head
            if (i_wrap) begin
                n_key    = i_head_key;
                n_handle = i_head_handle;
            end else begin
                n_key    = i_right_key;
                n_handle = i_right_handle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
    end

    assign o_key    = r_key;
    assign o_handle = r_handle;

endmodule

// ===== src/depth_sorted_insert_queue_core.sv =====
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+------------------------------------------
// request  | i_in_valid   | o_in_stall   | i_op, i_entry_handle, i_depth_key
// result   | o_out_valid  | i_out_stall  | o_out_handle, o_out_depth, o_status, o_last
// config   | i_cfg_wr_en  | -            | i_cfg_wr_data (descending_order)
//
// Insert, clear and unused ops give one result; only insert shifts the cell row.
// A drain of N entries gives N results: the row rotates one step per result,
// so after N steps the entries are back in place.
// One request at a time; a new request waits until the drain has finished.
// Synchronous active-low reset clears count, drain index, order, state and
// output valid; the cell row is not reset.
// A stalled result holds the output register and the cell row.
module depth_sorted_insert_queue_core #(
    parameter int unsigned QUEUE_CAPACITY = dsiq_pkg::QUEUE_CAPACITY_DEF,
    parameter int unsigned HANDLE_BITS    = dsiq_pkg::HANDLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_op,
    input  logic [dsiq_pkg::HANDLE_FIELD_W-1:0] i_entry_handle,
    input  dsiq_pkg::t_key                      i_depth_key,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dsiq_pkg::HANDLE_FIELD_W-1:0] o_out_handle,
    output dsiq_pkg::t_key                      o_out_depth,
    output logic [1:0]                          o_status,
    output logic                                o_last
);
    import dsiq_pkg::*;

`include "depth_sorted_insert_queue_core_defines.svh"

    localparam int unsigned HW   = (HANDLE_BITS < HANDLE_FIELD_W) ? HANDLE_BITS
                                                                  : HANDLE_FIELD_W;
    localparam int unsigned CntW = $clog2(QUEUE_CAPACITY + 1);

    logic                      r_desc;
    t_state                    r_state, n_state;
    logic [CntW-1:0]           r_count, n_count;
    logic [CntW-1:0]           r_idx, n_idx;
    logic                      r_out_valid, n_out_valid;
    logic [HW-1:0]             r_out_handle, n_out_handle;
    t_key                      r_out_depth, n_out_depth;
    t_status                   r_status, n_status;
    logic                      r_last, n_last;

    t_cell_ctl                 w_ctl;
    logic                      w_out_free;
    logic                      w_in_acc;
    logic                      w_full;
    logic                      w_drain_last;
    logic [HW-1:0]             w_new_handle;

    logic                      w_ge     [QUEUE_CAPACITY];
    t_key                      w_key    [QUEUE_CAPACITY];
    logic [HW-1:0]             w_handle [QUEUE_CAPACITY];

    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall   = !((r_state == S_IDLE) && w_out_free);
    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign w_full       = (r_count == CntW'(QUEUE_CAPACITY));
    assign w_drain_last = (r_idx == (r_count - CntW'(1)));
    assign w_new_handle = i_entry_handle[HW-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_CAPACITY; gi++) begin : g_cell
            logic          w_left_ge;
            t_key          w_left_key, w_right_key;
            logic [HW-1:0] w_left_handle, w_right_handle;

            if (gi == 0) begin : g_head
                assign w_left_ge     = 1'b0;
                assign w_left_key    = w_key[0];
                assign w_left_handle = w_handle[0];
            end else begin : g_body
                assign w_left_ge     = w_ge[gi-1];
                assign w_left_key    = w_key[gi-1];
                assign w_left_handle = w_handle[gi-1];
            end

            if (gi == QUEUE_CAPACITY - 1) begin : g_tail
                assign w_right_key    = w_key[gi];
                assign w_right_handle = w_handle[gi];
            end else begin : g_mid
                assign w_right_key    = w_key[gi+1];
                assign w_right_handle = w_handle[gi+1];
            end

            dsiq_cell #(
                .HW (HW)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctl          (w_ctl),
                .i_desc         (r_desc),
                .i_occupied     (r_count > CntW'(gi)),
                .i_wrap         (r_count == CntW'(gi + 1)),
                .i_new_key      (i_depth_key),
                .i_new_handle   (w_new_handle),
                .i_left_ge      (w_left_ge),
                .i_left_key     (w_left_key),
                .i_left_handle  (w_left_handle),
                .i_right_key    (w_right_key),
                .i_right_handle (w_right_handle),
                .i_head_key     (w_key[0]),
                .i_head_handle  (w_handle[0]),
                .o_ge           (w_ge[gi]),
                .o_key          (w_key[gi]),
                .o_handle       (w_handle[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid;
        n_out_handle = r_out_handle;
        n_out_depth  = r_out_depth;
        n_status     = r_status;
        n_last       = r_last;
        w_ctl        = '0;
        if (w_out_free) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_out_valid  = 1'b1;
                    n_out_handle = '0;
                    n_out_depth  = '0;
                    n_status     = ST_DONE;
                    n_last       = 1'b1;
                    case (i_op)
                        OP_INSERT: begin
                            if (w_full) begin
                                n_status = ST_REJECTED;
                            end else begin
                                w_ctl.insert = 1'b1;
                                n_count      = r_count + CntW'(1);
                            end
                        end
                        OP_DRAIN: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_idx       = '0;
                                n_state     = S_DRAIN;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                if (w_out_free) begin
                    w_ctl.rotate = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_handle = w_handle[0];
                    n_out_depth  = w_key[0];
                    n_status     = ST_DRAINED;
                    n_last       = w_drain_last;
                    n_idx        = r_idx + CntW'(1);
                    if (w_drain_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_desc      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_desc <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_handle <= n_out_handle;
        r_out_depth  <= n_out_depth;
        r_status     <= n_status;
        r_last       <= n_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_handle = HANDLE_FIELD_W'(r_out_handle);
    assign o_out_depth  = r_out_depth;
    assign o_status     = r_status;
    assign o_last       = r_last;

    `DSIQ_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CntW'(QUEUE_CAPACITY), "entry count above capacity")
    `DSIQ_ASSERT_IMPLY(a_drain_idx, i_clk, i_rst_n, r_state == S_DRAIN,
        r_idx < r_count, "drain index past entry count")
    `DSIQ_ASSERT_NEXT(a_insert_cnt, i_clk, i_rst_n,
        w_in_acc && (i_op == OP_INSERT) && !w_full,
        r_count == $past(r_count) + CntW'(1), "insert did not bump count")
    `DSIQ_ASSERT_NEXT(a_drain_end, i_clk, i_rst_n,
        (r_state == S_DRAIN) && w_out_free && w_drain_last,
        (r_state == S_IDLE) && o_last && o_out_valid, "drain did not end on last")

endmodule
